// ===== rtl/atcd_pkg.sv =====
// ----------------------------------------------------------------------------
// atcd_pkg
// Shared types and constants of the animated two-color dither core.
// ----------------------------------------------------------------------------
package atcd_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int unsigned ROW_STEP   = 2136141;
    localparam int unsigned FRAME_STEP = 85446;
    localparam logic [31:0] RNG_SEED   = 32'd12345;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_CHAOS = 2'd1,
        CFG_WIDTH = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STATIC = 2'd0,
        MODE_RANDOM = 2'd1,
        MODE_WAVE   = 2'd2,
        MODE_ALT    = 2'd3
    } t_mode;

    typedef struct packed {
        logic        action;
        logic [15:0] orange_prob;
        logic [11:0] col;
        logic [11:0] row;
    } t_in_item;

    typedef struct packed {
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        is_orange;
    } t_out_item;

endpackage

// ===== rtl/atcd_mul.sv =====
// ----------------------------------------------------------------------------
// atcd_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module atcd_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/atcd_sine_rom.sv =====
// ----------------------------------------------------------------------------
// atcd_sine_rom
// Full-turn sine table in Q1.15 with a registered read.
// ----------------------------------------------------------------------------
module atcd_sine_rom #(
    parameter int SINE_ENTRIES = atcd_pkg::SINE_ENTRIES_DEF,
    parameter int AW           = $clog2(SINE_ENTRIES)
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_addr,
    output logic signed [15:0] o_data
);

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [15:0] t_sine_tab [SINE_ENTRIES];

    function automatic t_sine_tab f_build();
        t_sine_tab   tab;
        logic [63:0] a4;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            a4   = 64'(i) * 64'd4;
            quad = a4 / SINE_ENTRIES;
            rem  = a4 % SINE_ENTRIES;
            if (quad[0]) begin
                rem = 64'(SINE_ENTRIES) - rem;
            end
            x  = rem * HALF_PI_Q30 / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[i] = (quad >= 64'd2) ? -$signed(v[15:0]) : $signed(v[15:0]);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build();

    logic signed [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== rtl/animated_two_color_dither_core.sv =====
// ----------------------------------------------------------------------------
// animated_two_color_dither_core
// Decides orange or black per pixel item, random or animated-wave threshold.
// ----------------------------------------------------------------------------
// One item at a time. Frame-end items and static-mode items finish with
// no result. Random-mode pixels go through the result state to the output
// register. In wave mode a sequencer runs six products (row phase, chaos
// term, sine times width, width times base, blend weight, final weight)
// through one shared registered 32x32 multiplier, with the sine table
// read registered in between. A result waiting in the output register
// holds the next result back until it is taken.
module animated_two_color_dither_core #(
    parameter int MAX_WIDTH    = atcd_pkg::MAX_WIDTH_DEF,
    parameter int SINE_ENTRIES = atcd_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  atcd_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output atcd_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atcd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [atcd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(SINE_ENTRIES);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PH   = 9'b000000010,
        S_ROM  = 9'b000000100,
        S_A    = 9'b000001000,
        S_B    = 9'b000010000,
        S_W    = 9'b000100000,
        S_D    = 9'b001000000,
        S_F    = 9'b010000000,
        S_RES  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_mode;
    logic [6:0]           r_chaos;
    logic [12:0]          r_row_width;
    logic [31:0]          r_rng, n_rng;
    logic [23:0]          r_phase;
    atcd_pkg::t_in_item   r_item;
    logic [15:0]          r_rnd;
    logic signed [31:0]   r_a;
    logic signed [31:0]   r_b;
    logic signed [63:0]   r_acc;
    logic                 r_orange;
    logic                 r_out_valid;
    atcd_pkg::t_out_item  r_out;

    logic                 in_acc;
    logic [6:0]           chaos_sat;
    logic [WW-1:0]        w_sat;
    logic [31:0]          rng_t0, rng_t1;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   prod;
    logic [23:0]          phase_cur;
    logic signed [15:0]   sin_q;
    logic signed [63:0]   sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        chaos_sat = (r_chaos > 7'd100) ? 7'd100 : r_chaos;
        if (r_row_width == 13'd0) begin
            w_sat = WW'(1);
        end else if (32'(r_row_width) > MAX_WIDTH) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(r_row_width);
        end
        rng_t0 = r_rng ^ (r_rng << 13);
        rng_t1 = rng_t0 ^ (rng_t0 >> 17);
        n_rng  = rng_t1 ^ (rng_t1 << 5);
    end

    assign phase_cur = prod[23:0] - r_phase;
    assign sum       = r_acc + prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PH: begin
                mul_a = 32'(r_item.row);
                mul_b = 32'(atcd_pkg::ROW_STEP);
            end
            S_ROM: begin
                mul_a = 32'(chaos_sat);
                mul_b = 32'({r_rnd, 2'b00}) - 32'sd131070;
            end
            S_A: begin
                mul_a = 32'(sin_q);
                mul_b = 32'(w_sat);
            end
            S_B: begin
                mul_a = 32'(w_sat);
                mul_b = r_a;
            end
            S_W: begin
                mul_a = 32'sd100 - 32'(chaos_sat);
                mul_b = 32'sd196605;
            end
            S_D: begin
                mul_a = prod[31:0];
                mul_b = r_b;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    atcd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    atcd_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .AW           (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (phase_cur[23 -: AW]),
        .o_data (sin_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_mode != atcd_pkg::MODE_STATIC && !i_in_item.action) begin
                    n_state = (r_mode == atcd_pkg::MODE_WAVE) ? S_PH : S_RES;
                end
            end
            S_PH:  n_state = S_ROM;
            S_ROM: n_state = S_A;
            S_A:   n_state = S_B;
            S_B:   n_state = S_W;
            S_W:   n_state = S_D;
            S_D:   n_state = S_F;
            S_F:   n_state = S_RES;
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= atcd_pkg::MODE_WAVE;
            r_chaos     <= 7'd10;
            r_row_width <= 13'd1920;
            r_rng       <= atcd_pkg::RNG_SEED;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    atcd_pkg::CFG_MODE:  r_mode      <= i_cfg_data[1:0];
                    atcd_pkg::CFG_CHAOS: r_chaos     <= i_cfg_data[6:0];
                    atcd_pkg::CFG_WIDTH: r_row_width <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && r_mode != atcd_pkg::MODE_STATIC) begin
                if (i_in_item.action) begin
                    r_phase <= r_phase + 24'(atcd_pkg::FRAME_STEP);
                end else if (r_mode != atcd_pkg::MODE_WAVE || chaos_sat != 7'd0) begin
                    r_rng <= n_rng;
                end
            end
            if (r_state == S_RES && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item   <= i_in_item;
            r_rnd    <= (chaos_sat != 7'd0) ? n_rng[15:0] : 16'd0;
            r_orange <= n_rng[15:0] < i_in_item.orange_prob;
        end
        case (r_state)
            S_A: r_a <= 32'(r_item.orange_prob) * 32'sd1000 + prod[31:0] - 32'sd32767500;
            S_B: r_b <= ((32'({r_item.col, 1'b0}) - 32'(w_sat)) <<< 15) - prod[31:0];
            S_W: r_acc <= prod <<< 15;
            S_F: r_orange <= (sum > 64'sd0);
            default: ;
        endcase
        if (r_state == S_RES && (!r_out_valid || i_out_ready)) begin
            r_out.out_col   <= r_item.col;
            r_out.out_row   <= r_item.row;
            r_out.is_orange <= r_orange;
        end
    end

    a_static_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_mode == atcd_pkg::MODE_STATIC |=> r_state == S_IDLE)
        else $error("static item started work");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.action && r_mode != atcd_pkg::MODE_STATIC
        |=> r_phase == $past(r_phase) + 24'(atcd_pkg::FRAME_STEP))
        else $error("frame end did not advance phase");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RES && r_out_valid && !i_out_ready |=> r_state == S_RES)
        else $error("result overwrote pending item");

    a_wave_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PH |=> ##6 r_state == S_RES)
        else $error("wave sequence length broken");

endmodule
